[design/hti_pkg.sv]
// Shared types and constants of the height-map triangle interpolator.
package hti_pkg;

  localparam int unsigned GV_W   = 7;   // grid_vertices register width
  localparam int unsigned TS_W   = 31;  // terrain_size register width
  localparam int unsigned H_W    = 16;  // Q8.8 height width
  localparam int unsigned POS_W  = 32;  // Q16.16 position width
  localparam int unsigned N_W    = 9;   // effective vertex count, up to 127
  localparam int unsigned DIV_W  = 48;  // divider dividend and quotient width
  localparam int unsigned DCNT_W = 6;   // divider step counter width
  localparam int unsigned ACC_W  = 48;  // blend accumulator width

  localparam logic [GV_W-1:0] GV_RESET = 7'd64;
  localparam logic [TS_W-1:0] TS_RESET = 31'd4194304;

  // Configuration register indexes.
  localparam logic CFG_GRID_VERTICES = 1'b0;
  localparam logic CFG_TERRAIN_SIZE  = 1'b1;

  // Operation codes carried in the input tuser.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Height map port controls.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } map_ctl_t;

endpackage

[design/hti_div.sv]
// Restoring divider, one quotient bit per cycle, shared by all divisions.
module hti_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [hti_pkg::DIV_W-1:0]     dividend_i,
  input  logic [hti_pkg::TS_W-1:0]      divisor_i,
  output logic                          done_o,
  output logic [hti_pkg::DIV_W-1:0]     quot_o,
  output logic [hti_pkg::TS_W-1:0]      rem_o
);

  localparam logic [hti_pkg::DCNT_W-1:0] LAST_STEP = hti_pkg::DCNT_W'(hti_pkg::DIV_W - 1);

  logic                          busy_q;
  logic                          done_q;
  logic [hti_pkg::DCNT_W-1:0]    cnt_q;
  logic [hti_pkg::DIV_W-1:0]     dvd_q;
  logic [hti_pkg::TS_W-1:0]      rem_q;
  logic [hti_pkg::TS_W-1:0]      dsr_q;
  logic [hti_pkg::TS_W:0]        trial;
  logic                          fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem_q, dvd_q[hti_pkg::DIV_W-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[hti_pkg::DIV_W-2:0], fits};
      rem_q <= fits ? hti_pkg::TS_W'(trial - {1'b0, dsr_q}) : hti_pkg::TS_W'(trial);
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

endmodule

[design/hti_map.sv]
// Height map memory with a zero-fill sweep after reset.
module hti_map #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hti_pkg::map_ctl_t             ctl_i,
  input  logic [$clog2(DEPTH)-1:0]      waddr_i,
  input  logic [hti_pkg::H_W-1:0]       wdata_i,
  input  logic [$clog2(DEPTH)-1:0]      raddr_i,
  output logic [hti_pkg::H_W-1:0]       rdata_o,
  output logic                          ready_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  logic [hti_pkg::H_W-1:0] mem [DEPTH];
  logic [hti_pkg::H_W-1:0] rdata_q;
  logic                    clr_q;
  logic [AW-1:0]           clr_addr_q;
  logic                    we;
  logic [AW-1:0]           wa;
  logic [hti_pkg::H_W-1:0] wd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == LAST_ADDR) begin
        clr_q <= 1'b0;
      end
    end
  end

  // The sweep owns the write port until every entry holds zero.
  assign we = clr_q | ctl_i.wr_en;
  assign wa = clr_q ? clr_addr_q : waddr_i;
  assign wd = clr_q ? '0 : wdata_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign ready_o = !clr_q;

endmodule

[design/heightmap_triangle_interpolator.sv]
// Top level of the height-map triangle interpolator: control, blend and ports.
//
// The block stores a GRID_MAX by GRID_MAX map of signed Q8.8 heights and
// answers each beat on the input stream with exactly one result beat. A
// write beat (tuser 0) stores one entry if its row and column lie inside
// the map and answers height 0 with in_range clear; a query beat (tuser 1)
// finds the grid cell of a Q16.16 x,z position, picks the lower or upper
// triangle of that cell and returns the rounded, saturated barycentric
// blend of its three corner heights, or height 0 with in_range clear when
// the position lies outside the grid or the cell size is zero. After reset
// the map is swept to zero, one entry per cycle, over all GRID_MAX*GRID_MAX
// entries (4096 at the default) before the first input beat is taken;
// configuration writes are taken at any time. The block works on one item
// at a time. An in-range query runs four divisions on one shared bit-serial
// divider (cell size, x, z and the final scaling) plus four
// read-multiply-accumulate rounds over the single map read port. A finished
// result sits in the output register, so the next beat can be taken while the consumer still stalls.
module heightmap_triangle_interpolator #(
  parameter int unsigned GRID_MAX = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [30:0] cfg_data_i,
  // Input stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata from bit 0: pos_x[31:0], pos_z[63:32], write_col[69:64],
  // write_row[75:70], write_height[91:76], zero fill [95:92].
  input  logic [95:0] s_axis_tdata_i,
  // tuser: opcode[0].
  input  logic [0:0]  s_axis_tuser_i,
  // Output stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: height[15:0].
  output logic [15:0] m_axis_tdata_o,
  // tuser: in_range[0].
  output logic [0:0]  m_axis_tuser_o
);

  localparam int unsigned DEPTH = GRID_MAX * GRID_MAX;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned IW    = $clog2(GRID_MAX);
  localparam logic [hti_pkg::N_W-1:0] N_MAX = hti_pkg::N_W'(GRID_MAX);
  localparam logic [AW-1:0] ROW_STRIDE = AW'(GRID_MAX);

  typedef enum logic [13:0] {
    S_CLR  = 14'b00000000000001,
    S_IDLE = 14'b00000000000010,
    S_WR   = 14'b00000000000100,
    S_XGO  = 14'b00000000001000,
    S_DX   = 14'b00000000010000,
    S_ZGO  = 14'b00000000100000,
    S_DZ   = 14'b00000001000000,
    S_CHK  = 14'b00000010000000,
    S_RD   = 14'b00000100000000,
    S_MUL  = 14'b00001000000000,
    S_ACC  = 14'b00010000000000,
    S_FGO  = 14'b00100000000000,
    S_FDIV = 14'b01000000000000,
    S_OUT  = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [hti_pkg::GV_W-1:0] gv_q;
  logic [hti_pkg::TS_W-1:0] ts_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gv_q <= hti_pkg::GV_RESET;
      ts_q <= hti_pkg::TS_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        hti_pkg::CFG_GRID_VERTICES: gv_q <= cfg_data_i[hti_pkg::GV_W-1:0];
        hti_pkg::CFG_TERRAIN_SIZE:  ts_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective vertex count, clamped to 2..GRID_MAX, and the cell count n-1.
  logic [hti_pkg::N_W-1:0] gv_ext, n_eff, nm1;
  assign gv_ext = hti_pkg::N_W'(gv_q);
  assign n_eff  = (gv_ext < hti_pkg::N_W'(2)) ? hti_pkg::N_W'(2) :
                  (gv_ext > N_MAX) ? N_MAX : gv_ext;
  assign nm1    = n_eff - 1'b1;

  // Input beat fields.
  logic in_acc;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;

  logic [hti_pkg::POS_W-1:0] px_q, pz_q;
  logic [5:0]                col_q, row_q;
  logic [hti_pkg::H_W-1:0]   wh_q;
  logic [hti_pkg::N_W-1:0]   nm1_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px_q  <= s_axis_tdata_i[31:0];
      pz_q  <= s_axis_tdata_i[63:32];
      col_q <= s_axis_tdata_i[69:64];
      row_q <= s_axis_tdata_i[75:70];
      wh_q  <= s_axis_tdata_i[91:76];
      nm1_q <= nm1;
    end
  end

  // Shared divider.
  logic                        div_start, div_done;
  logic [hti_pkg::DIV_W-1:0]   div_dvd, div_quot;
  logic [hti_pkg::TS_W-1:0]    div_dsr, div_rem;

  hti_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Query working registers.
  logic [hti_pkg::TS_W-1:0]   cell_q, fx_q, fz_q;
  logic [IW-1:0]              gx_q, gz_q;
  logic                       xbad_q, zbad_q;
  logic [1:0]                 corner_q;
  logic signed [hti_pkg::ACC_W-1:0] acc_q, prod_q;
  logic [hti_pkg::H_W-1:0]    res_h_q;
  logic                       res_ok_q;

  // The cell-size division runs while the sequencer waits in S_XGO; this
  // flag marks that the cell is known, so S_XGO can start the x division.
  logic cell_ok_q;

  // A query is answered with zero when the cell size is zero or either
  // coordinate is negative.
  logic early_zero;
  assign early_zero = (cell_q == '0) | px_q[hti_pkg::POS_W-1] | pz_q[hti_pkg::POS_W-1];

  // Rounding offset: floor(cell/2) plus one for an odd cell.
  logic [hti_pkg::TS_W-1:0]  half_up;
  logic                      acc_neg;
  logic [hti_pkg::DIV_W-1:0] acc_mag;
  assign half_up = {1'b0, cell_q[hti_pkg::TS_W-1:1]} + hti_pkg::TS_W'(cell_q[0]);
  assign acc_neg = acc_q[hti_pkg::ACC_W-1];
  assign acc_mag = acc_neg ? hti_pkg::DIV_W'(-acc_q) : hti_pkg::DIV_W'(acc_q);

  always_comb begin
    div_start = 1'b0;
    div_dvd   = hti_pkg::DIV_W'(ts_q);
    div_dsr   = hti_pkg::TS_W'(nm1);
    unique case (state_q)
      S_IDLE: begin
        div_start = in_acc & (s_axis_tuser_i[0] == hti_pkg::OP_QUERY);
      end
      S_XGO: begin
        div_start = cell_ok_q & !early_zero;
        div_dvd   = hti_pkg::DIV_W'(px_q[hti_pkg::POS_W-2:0]);
        div_dsr   = cell_q;
      end
      S_ZGO: begin
        div_start = 1'b1;
        div_dvd   = hti_pkg::DIV_W'(pz_q[hti_pkg::POS_W-2:0]);
        div_dsr   = cell_q;
      end
      S_FGO: begin
        div_start = 1'b1;
        div_dvd   = acc_mag + hti_pkg::DIV_W'(half_up);
        div_dsr   = cell_q;
      end
      default: ;
    endcase
  end

  // Triangle choice and corner weights; corners are ordered (0,0), (1,0),
  // (0,1), (1,1) with bit 0 the column step and bit 1 the row step.
  logic [hti_pkg::TS_W:0]   fsum;
  logic                     lower;
  logic [hti_pkg::TS_W-1:0] weight;
  assign fsum  = {1'b0, fx_q} + {1'b0, fz_q};
  assign lower = fsum <= {1'b0, cell_q};

  always_comb begin
    weight = '0;
    unique case (corner_q)
      2'd0: weight = lower ? hti_pkg::TS_W'({1'b0, cell_q} - fsum) : '0;
      2'd1: weight = lower ? fx_q : cell_q - fz_q;
      2'd2: weight = lower ? fz_q : cell_q - fx_q;
      2'd3: weight = lower ? '0 : hti_pkg::TS_W'(fsum - {1'b0, cell_q});
      default: ;
    endcase
  end

  // Height map access.
  hti_pkg::map_ctl_t       map_ctl;
  logic [AW-1:0]           map_waddr, map_raddr;
  logic [hti_pkg::H_W-1:0] map_rdata;
  logic                    map_ready;
  logic                    wr_inside;
  logic [IW-1:0]           rd_col, rd_row;

  assign wr_inside = (hti_pkg::N_W'(col_q) < N_MAX) & (hti_pkg::N_W'(row_q) < N_MAX);
  assign map_waddr = AW'(row_q) * ROW_STRIDE + AW'(col_q);
  assign rd_col    = gx_q + IW'(corner_q[0]);
  assign rd_row    = gz_q + IW'(corner_q[1]);
  assign map_raddr = AW'(rd_row) * ROW_STRIDE + AW'(rd_col);

  always_comb begin
    map_ctl       = '0;
    map_ctl.wr_en = (state_q == S_WR) & wr_inside;
    map_ctl.rd_en = (state_q == S_RD);
  end

  hti_map #(
    .DEPTH (DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (map_ctl),
    .waddr_i (map_waddr),
    .wdata_i (wh_q),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata),
    .ready_o (map_ready)
  );

  logic signed [hti_pkg::ACC_W-1:0] prod_d;
  assign prod_d = $signed(map_rdata) * $signed({1'b0, weight});

  // Final quotient with saturation to the Q8.8 range.
  logic [hti_pkg::H_W-1:0] sat_h;
  always_comb begin
    if (acc_neg) begin
      sat_h = (div_quot > hti_pkg::DIV_W'(32768)) ? 16'h8000 :
              hti_pkg::H_W'(-div_quot[hti_pkg::H_W-1:0]);
    end else begin
      sat_h = (div_quot > hti_pkg::DIV_W'(32767)) ? 16'h7fff : div_quot[hti_pkg::H_W-1:0];
    end
  end

  // Output register.
  logic                    m_valid_q;
  logic [hti_pkg::H_W-1:0] m_data_q;
  logic                    m_user_q;
  logic                    out_free;
  assign out_free = !m_valid_q | m_axis_tready_i;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:  if (map_ready) state_d = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          state_d = (s_axis_tuser_i[0] == hti_pkg::OP_QUERY) ? S_XGO : S_WR;
        end
      end
      S_WR:   state_d = S_OUT;
      S_XGO:  begin
        // Wait for the cell-size division before starting on x.
        if (cell_ok_q) state_d = early_zero ? S_OUT : S_DX;
      end
      S_DX:   if (div_done) state_d = S_ZGO;
      S_ZGO:  state_d = S_DZ;
      S_DZ:   if (div_done) state_d = S_CHK;
      S_CHK:  state_d = (xbad_q | zbad_q) ? S_OUT : S_RD;
      S_RD:   state_d = S_MUL;
      S_MUL:  state_d = S_ACC;
      S_ACC:  state_d = (corner_q == 2'd3) ? S_FGO : S_RD;
      S_FGO:  state_d = S_FDIV;
      S_FDIV: if (div_done) state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      cell_ok_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (state_q == S_IDLE) begin
        cell_ok_q <= 1'b0;
      end else if (state_q == S_XGO && div_done) begin
        cell_ok_q <= 1'b1;
      end
      state_q <= state_d;
      if (state_q == S_OUT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        res_h_q  <= '0;
        res_ok_q <= 1'b0;
      end
      S_XGO: begin
        if (div_done) begin
          cell_q <= div_quot[hti_pkg::TS_W-1:0];
        end
      end
      S_DX: begin
        if (div_done) begin
          gx_q   <= div_quot[IW-1:0];
          fx_q   <= div_rem;
          xbad_q <= div_quot >= hti_pkg::DIV_W'(nm1_q);
        end
      end
      S_DZ: begin
        if (div_done) begin
          gz_q   <= div_quot[IW-1:0];
          fz_q   <= div_rem;
          zbad_q <= div_quot >= hti_pkg::DIV_W'(nm1_q);
        end
      end
      S_CHK: begin
        corner_q <= 2'd0;
        acc_q    <= '0;
      end
      S_MUL: begin
        prod_q <= prod_d;
      end
      S_ACC: begin
        acc_q    <= acc_q + prod_q;
        corner_q <= corner_q + 1'b1;
      end
      S_FDIV: begin
        if (div_done) begin
          res_h_q  <= sat_h;
          res_ok_q <= 1'b1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          m_data_q <= res_h_q;
          m_user_q <= res_ok_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o   = m_valid_q;
  assign m_axis_tdata_o    = m_data_q;
  assign m_axis_tuser_o[0] = m_user_q;

endmodule
